>>> design/aseq_pkg.sv
// Package for the angle sequence unwrapper: shared codes, widths, the controller
// state encoding and the command struct between controller and datapath.
// No dependencies.
`default_nettype none

package aseq_pkg;

	// Defaults for the top level parameters.
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int ANGLE_BITS_DEF  = 32;
	localparam int TURN_SHIFT_DEF  = 16;

	// Fixed port widths.
	localparam int ANGLE_W  = 32;
	localparam int INDEX_W  = 10;
	localparam int STATUS_W = 2;

	// Opcodes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Status codes returned with a read.
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_PENDING = 2'd2;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // store a sample
		logic read;    // issue a store read and capture its status
		logic finish;  // compute the centre offset and close the sequence
		logic emit;    // load the output register
	} cmd_t;

endpackage

`default_nettype wire

>>> design/aseq_ctrl.sv
// Controller for the angle sequence unwrapper: accepts transactions, sequences
// reads and sequence completion, and owns the output valid flag. Uses aseq_pkg.
`default_nettype none

module aseq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          opcode,
	input  wire logic          last_in,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output aseq_pkg::cmd_t     cmd
);

	aseq_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic emit_ok;

	// The output register may be loaded when empty or when it is being taken.
	assign emit_ok = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			aseq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (opcode == aseq_pkg::OP_READ) begin
						cmd.read = 1'b1;
						state_d  = aseq_pkg::ST_READ;
					end else begin
						cmd.load = 1'b1;
						if (last_in) begin
							state_d = aseq_pkg::ST_FIN;
						end
					end
				end
			end
			aseq_pkg::ST_READ: begin
				if (emit_ok) begin
					cmd.emit = 1'b1;
					state_d  = aseq_pkg::ST_IDLE;
				end
			end
			aseq_pkg::ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = aseq_pkg::ST_IDLE;
			end
			default: begin
				state_d = aseq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aseq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> design/aseq_dp.sv
// Datapath for the angle sequence unwrapper: unwrap arithmetic, the sample store,
// the centre offset and the output register. Driven by aseq_ctrl; uses aseq_pkg.
`default_nettype none

module aseq_dp #(
	parameter int MAX_SAMPLES = aseq_pkg::MAX_SAMPLES_DEF,
	parameter int ANGLE_BITS  = aseq_pkg::ANGLE_BITS_DEF,
	parameter int TURN_SHIFT  = aseq_pkg::TURN_SHIFT_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire aseq_pkg::cmd_t                       cmd,
	input  wire logic signed [aseq_pkg::ANGLE_W-1:0]  angle_in,
	input  wire logic        [aseq_pkg::INDEX_W-1:0]  read_index,
	output logic signed      [aseq_pkg::ANGLE_W-1:0]  angle_out,
	output logic             [aseq_pkg::STATUS_W-1:0] status
);

	// Held width of unwrapped values; widths beyond 62 bits behave as 62.
	localparam int EFF = (ANGLE_BITS >= 62) ? 62 : ANGLE_BITS;
	localparam int MW0 = (EFF > TURN_SHIFT + 1) ? EFF : TURN_SHIFT + 1;
	localparam int MW1 = (MW0 > aseq_pkg::ANGLE_W + 1) ? MW0 : aseq_pkg::ANGLE_W + 1;
	// Working width for sums before saturation.
	localparam int SW  = MW1 + 4;
	localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int XW  = (CW > aseq_pkg::INDEX_W) ? CW : aseq_pkg::INDEX_W;

	localparam logic signed [SW-1:0] SAT_HI = {{(SW-EFF+1){1'b0}}, {(EFF-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [SW-1:0] TURN_X = {{(SW-TURN_SHIFT-1){1'b0}}, 1'b1,
		{TURN_SHIFT{1'b0}}};
	localparam logic [TURN_SHIFT-1:0] HALF  = {1'b1, {(TURN_SHIFT-1){1'b0}}};
	localparam logic [CW-1:0]        MAX_C  = CW'(MAX_SAMPLES);

	function automatic logic signed [EFF-1:0] sat_eff(input logic signed [SW-1:0] x);
		logic signed [EFF-1:0] y;
		if (x > SAT_HI) begin
			y = SAT_HI[EFF-1:0];
		end else if (x < SAT_LO) begin
			y = SAT_LO[EFF-1:0];
		end else begin
			y = x[EFF-1:0];
		end
		return y;
	endfunction

	function automatic logic signed [SW-1:0] sext_eff(input logic signed [EFF-1:0] x);
		return {{(SW-EFF){x[EFF-1]}}, x};
	endfunction

	logic signed [EFF-1:0] mem [MAX_SAMPLES];

	logic signed [EFF-1:0] prev_q, first_q, offset_q, rd_data_q;
	logic        [CW-1:0]  count_q;
	logic                  done_q;
	logic [aseq_pkg::STATUS_W-1:0] rd_status_q;
	logic signed [aseq_pkg::ANGLE_W-1:0] angle_out_q;
	logic        [aseq_pkg::STATUS_W-1:0] status_q;

	// Load path.
	logic        [CW-1:0]         cnt_eff;
	logic                         has_room;
	logic signed [SW-1:0]         s_x, prev_x, r_x, adj_x, unw_x;
	logic        [TURN_SHIFT-1:0] r;
	logic signed [EFF-1:0]        v;

	assign cnt_eff  = done_q ? '0 : count_q;
	assign has_room = cnt_eff < MAX_C;
	assign s_x      = {{(SW-aseq_pkg::ANGLE_W){angle_in[aseq_pkg::ANGLE_W-1]}}, angle_in};
	assign prev_x   = sext_eff(prev_q);
	// Only the low bits of prev - s decide the remainder within one turn.
	assign r        = prev_x[TURN_SHIFT-1:0] - s_x[TURN_SHIFT-1:0];
	assign r_x      = {{(SW-TURN_SHIFT){1'b0}}, r};
	assign adj_x    = (r > HALF) ? (TURN_X - r_x) : -r_x;
	assign unw_x    = prev_x + adj_x;
	assign v        = (cnt_eff == '0) ? sat_eff(s_x) : sat_eff(unw_x);

	// Finish path: offset = floor((first + last + turn) / 2 turns) turns.
	logic signed [SW-1:0] sum_x, half_x, off_x;
	assign sum_x  = sext_eff(first_q) + prev_x + TURN_X;
	assign half_x = sum_x >>> (TURN_SHIFT + 1);
	assign off_x  = half_x <<< TURN_SHIFT;

	// Read path.
	logic [XW-1:0] idx_x;
	logic [aseq_pkg::STATUS_W-1:0] rd_status;
	logic signed [SW-1:0] diff_x, res_x;
	assign idx_x = XW'(read_index);
	always_comb begin
		priority if (!done_q) begin
			rd_status = aseq_pkg::STATUS_PENDING;
		end else if (idx_x >= XW'(count_q)) begin
			rd_status = aseq_pkg::STATUS_RANGE;
		end else begin
			rd_status = aseq_pkg::STATUS_OK;
		end
	end
	assign diff_x = sext_eff(rd_data_q) - sext_eff(offset_q);
	assign res_x  = sext_eff(sat_eff(diff_x));

	// Sample store: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			mem[cnt_eff[AW-1:0]] <= v;
		end
		if (cmd.read) begin
			rd_data_q <= mem[idx_x[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			first_q     <= '0;
			offset_q    <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			rd_status_q <= aseq_pkg::STATUS_OK;
		end else begin
			if (cmd.load) begin
				done_q <= 1'b0;
				if (has_room) begin
					prev_q  <= v;
					count_q <= cnt_eff + CW'(1);
					if (cnt_eff == '0) begin
						first_q <= v;
					end
				end else begin
					count_q <= cnt_eff;
				end
			end
			if (cmd.finish) begin
				offset_q <= sat_eff(off_x);
				done_q   <= 1'b1;
			end
			if (cmd.read) begin
				rd_status_q <= rd_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q    <= rd_status_q;
			angle_out_q <= (rd_status_q == aseq_pkg::STATUS_OK) ?
				res_x[aseq_pkg::ANGLE_W-1:0] : '0;
		end
	end

	assign angle_out = angle_out_q;
	assign status    = status_q;

endmodule

`default_nettype wire

>>> design/angle_sequence_unwrap_recenter_top.sv
// Top level of the angle sequence unwrapper with recentring: joins the
// controller (aseq_ctrl) and the datapath (aseq_dp). Uses aseq_pkg.
//
// Use of the block:
// The input channel (in_valid / in_stall) carries one transaction per item:
// opcode 0 loads a wrapped angle sample (angle_in, last_in), opcode 1 reads
// back the unwrapped entry at read_index. A transaction is taken at a rising
// edge where in_valid is high and in_stall is low. Loads give no result; each
// read gives exactly one result transaction on the output channel
// (out_valid / out_stall) with angle_out and status.
// Loads sustain one per cycle, except that a load marked last is followed by a
// step, with the input stalled, that computes the centre offset in the finish
// path. A read keeps the input stalled until its result enters the output
// register: the sample store has a registered read port, so the entry is
// registered first and loaded into the output register from the READ state.
// While a result waits in the output register, further loads are still taken;
// a read is held in the READ state until the output register frees.
// Reset clears the sequence: no samples, no completed sequence, zero offset,
// no pending result. The store contents are not cleared and need no pass.
`default_nettype none

module angle_sequence_unwrap_recenter_top #(
	parameter int MAX_SAMPLES = aseq_pkg::MAX_SAMPLES_DEF,
	parameter int ANGLE_BITS  = aseq_pkg::ANGLE_BITS_DEF,
	parameter int TURN_SHIFT  = aseq_pkg::TURN_SHIFT_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 opcode,
	input  wire logic signed [aseq_pkg::ANGLE_W-1:0]  angle_in,
	input  wire logic                                 last_in,
	input  wire logic        [aseq_pkg::INDEX_W-1:0]  read_index,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [aseq_pkg::ANGLE_W-1:0]  angle_out,
	output logic             [aseq_pkg::STATUS_W-1:0] status
);

	aseq_pkg::cmd_t cmd;

	// The controller decides when transactions are taken and when the output
	// register is loaded.
	aseq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.last_in   (last_in),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// The datapath holds the running unwrap state, the store and the offset.
	aseq_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.ANGLE_BITS  (ANGLE_BITS),
		.TURN_SHIFT  (TURN_SHIFT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.angle_in   (angle_in),
		.read_index (read_index),
		.angle_out  (angle_out),
		.status     (status)
	);

	// A result is loaded only into an empty output register or one being taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && out_stall))
		else $error("output register overwritten while a result waits");

	// Loading the output register always presents a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("result lost after output register load");

	// An accepted read keeps the input stalled while its result is formed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == aseq_pkg::OP_READ) |=> in_stall)
		else $error("transaction taken while a read is in flight");

	// A final sample is followed by the offset computation cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == aseq_pkg::OP_LOAD && last_in)
		|=> (cmd.finish && in_stall))
		else $error("sequence end without offset computation");

endmodule

`default_nettype wire
